/* design/lzwc_pkg.sv */
package lzwc_pkg;

   // codes below this stand for single bytes
   localparam int unsigned FIRST_FREE = 256;
   localparam int unsigned BYTE_BITS  = 8;

   // control part of a search beat moving down the cell row
   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } token_ctrl_type;

endpackage

/* design/lzwc_ram.sv */
module lzwc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lzwc_cell.sv */
module lzwc_cell
   import lzwc_pkg::*;
#(
   parameter int CODE_BITS  = 12,
   parameter int CELLS      = 16,
   parameter int CELL_INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [CODE_BITS-1:0]                 query_prefix,
   input  logic [BYTE_BITS-1:0]                 query_byte,
   input  logic [CODE_BITS-1:0]                 free_code,
   input  token_ctrl_type                       in_ctrl,
   input  logic [CODE_BITS-$clog2(CELLS)-1:0]   in_row,
   input  logic [CODE_BITS-1:0]                 in_code,
   output token_ctrl_type                       out_ctrl,
   output logic [CODE_BITS-$clog2(CELLS)-1:0]   out_row,
   output logic [CODE_BITS-1:0]                 out_code,
   input  logic                                 tbl_we,
   input  logic [CODE_BITS-1:0]                 tbl_code,
   input  logic [CODE_BITS+BYTE_BITS-1:0]       tbl_data
);

   localparam int CELL_BITS = $clog2(CELLS);
   localparam int ROW_BITS  = CODE_BITS - CELL_BITS;
   localparam int ROWS      = 1 << ROW_BITS;
   localparam int ENT_BITS  = CODE_BITS + BYTE_BITS;
   localparam logic [CELL_BITS-1:0] LANE = CELL_BITS'(CELL_INDEX);

   token_ctrl_type         ctrl_a_ff, ctrl_out_ff;
   logic [ROW_BITS-1:0]    row_a_ff, row_out_ff;
   logic [CODE_BITS-1:0]   code_a_ff, code_out_ff;
   logic [ENT_BITS-1:0]    entry;
   logic [CODE_BITS-1:0]   entry_code;
   logic                   match;
   logic                   bank_we;
   token_ctrl_type         ctrl_out_in;
   logic [CODE_BITS-1:0]   code_out_in;

   // entry k sits in bank k mod CELLS at row k / CELLS
   assign bank_we = tbl_we && (tbl_code[CELL_BITS-1:0] == LANE);

   lzwc_ram #(
      .WIDTH (ENT_BITS),
      .DEPTH (ROWS)
   ) u_bank (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (tbl_code[CODE_BITS-1:CELL_BITS]),
      .wr_data (tbl_data),
      .rd_en   (in_ctrl.valid),
      .rd_addr (in_row),
      .rd_data (entry)
   );

   assign entry_code = {row_a_ff, LANE};

   always_comb begin
      match = ctrl_a_ff.valid
              && (entry_code >= CODE_BITS'(FIRST_FREE))
              && (entry_code < free_code)
              && (entry[ENT_BITS-1:BYTE_BITS] == query_prefix)
              && (entry[BYTE_BITS-1:0] == query_byte);
      ctrl_out_in     = ctrl_a_ff;
      ctrl_out_in.hit = ctrl_a_ff.hit | match;
      code_out_in     = match ? entry_code : code_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff   <= '0;
         ctrl_out_ff <= '0;
      end else begin
         ctrl_a_ff   <= in_ctrl;
         ctrl_out_ff <= ctrl_out_in;
      end
      row_a_ff    <= in_row;
      code_a_ff   <= in_code;
      row_out_ff  <= row_a_ff;
      code_out_ff <= code_out_in;
   end

   assign out_ctrl = ctrl_out_ff;
   assign out_row  = row_out_ff;
   assign out_code = code_out_ff;

endmodule

/* design/lzw_compressor_12bit_unit.sv */
// LZW compressor, one byte per input beat, one dictionary code per output beat.
// req channel: tdata[7:0] is the byte, tlast marks the final byte of a stream.
// rsp channel: tdata holds the code in its low CODE_BITS bits, tlast marks the
// final code of the stream. A byte gives zero, one or two codes.
// The dictionary is spread over a row of CELLS cells, each owning one bank of
// the phrase table; a search beat enters the row every cycle, one bank row each,
// and each cell registers a bank read and then a compare.
// The first byte of a stream opens a phrase without a search. A later byte,
// while only the single byte codes exist, is a miss without a search; otherwise
// the search time grows with the number of bank rows to scan and the depth of
// the cell row.
// Codes queue in a four-entry buffer; a byte is taken while up to two codes
// still wait, and a stalled receiver holds the block once three codes wait.
// Reset empties the buffer and starts a fresh stream with an empty dictionary;
// after a final byte the block returns to that same state by itself.
// CELLS must be a power of two from 2 to 256.
module lzw_compressor_12bit_unit
   import lzwc_pkg::*;
#(
   parameter int CODE_BITS = 12,
   parameter int CELLS     = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // data_byte
   input  logic                            req_tlast,  // end_of_stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((CODE_BITS+7)/8)*8-1:0]  rsp_tdata,  // code
   output logic                            rsp_tlast   // last_code
);

   localparam int CELL_BITS = $clog2(CELLS);
   localparam int ROW_BITS  = CODE_BITS - CELL_BITS;
   localparam int Q_DEPTH   = 4;
   localparam int Q_BITS    = 2;
   localparam logic [ROW_BITS-1:0] FIRST_ROW = ROW_BITS'(FIRST_FREE / CELLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MISS,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [CODE_BITS-1:0]   phrase_ff, phrase_in;
   logic                   open_ff, open_in;
   logic [CODE_BITS-1:0]   free_ff, free_in;
   logic [BYTE_BITS-1:0]   byte_ff, byte_in;
   logic                   eos_ff, eos_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic                   issue_ff, issue_in;
   logic                   found_ff, found_in;
   logic [CODE_BITS-1:0]   found_code_ff, found_code_in;

   logic [CODE_BITS-1:0]   q_code_ff [Q_DEPTH];
   logic                   q_last_ff [Q_DEPTH];
   logic [Q_BITS-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [Q_BITS:0]        count_ff, count_in;

   logic                   req_fire, rsp_fire;
   logic                   push, push_last;
   logic [CODE_BITS-1:0]   push_code;
   logic [CODE_BITS-1:0]   free_m1;
   logic [ROW_BITS-1:0]    last_row;
   logic                   hit_any;
   logic [CODE_BITS-1:0]   hit_code;

   logic                   tbl_we;
   logic [CODE_BITS+BYTE_BITS-1:0] tbl_data;

   token_ctrl_type         chain_ctrl [CELLS+1];
   logic [ROW_BITS-1:0]    chain_row  [CELLS+1];
   logic [CODE_BITS-1:0]   chain_code [CELLS+1];

   assign req_tready = (state_ff == ST_IDLE) && (count_ff <= (Q_BITS+1)'(Q_DEPTH - 2));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[CODE_BITS-1:0]   = q_code_ff[rd_ptr_ff];
   end
   assign rsp_tlast = q_last_ff[rd_ptr_ff];

   assign free_m1  = free_ff - CODE_BITS'(1);
   assign last_row = free_m1[CODE_BITS-1:CELL_BITS];

   // head of the cell row: valid, last, hit
   assign chain_ctrl[0] = {(state_ff == ST_SEARCH) && issue_ff, row_ff == last_row, 1'b0};
   assign chain_row[0]  = row_ff;
   assign chain_code[0] = '0;

   // learn only while a code below the top one is free
   assign tbl_we   = (state_ff == ST_MISS) && !(&free_ff);
   assign tbl_data = {phrase_ff, byte_ff};

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      lzwc_cell #(
         .CODE_BITS  (CODE_BITS),
         .CELLS      (CELLS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .query_prefix (phrase_ff),
         .query_byte   (byte_ff),
         .free_code    (free_ff),
         .in_ctrl      (chain_ctrl[i]),
         .in_row       (chain_row[i]),
         .in_code      (chain_code[i]),
         .out_ctrl     (chain_ctrl[i+1]),
         .out_row      (chain_row[i+1]),
         .out_code     (chain_code[i+1]),
         .tbl_we       (tbl_we),
         .tbl_code     (free_ff),
         .tbl_data     (tbl_data)
      );
   end

   assign hit_any  = found_ff | chain_ctrl[CELLS].hit;
   assign hit_code = chain_ctrl[CELLS].hit ? chain_code[CELLS] : found_code_ff;

   always_comb begin
      state_in      = state_ff;
      phrase_in     = phrase_ff;
      open_in       = open_ff;
      free_in       = free_ff;
      byte_in       = byte_ff;
      eos_in        = eos_ff;
      row_in        = row_ff;
      issue_in      = issue_ff;
      found_in      = found_ff;
      found_code_in = found_code_ff;
      push          = 1'b0;
      push_code     = phrase_ff;
      push_last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in = req_tdata;
               eos_in  = req_tlast;
               if (!open_ff) begin
                  phrase_in = CODE_BITS'(req_tdata);
                  open_in   = 1'b1;
                  state_in  = ST_FINISH;
               end else if (free_ff == CODE_BITS'(FIRST_FREE)) begin
                  state_in = ST_MISS;
               end else begin
                  row_in   = FIRST_ROW;
                  issue_in = 1'b1;
                  found_in = 1'b0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (issue_ff) begin
               if (row_ff == last_row) begin
                  issue_in = 1'b0;
               end else begin
                  row_in = row_ff + ROW_BITS'(1);
               end
            end
            if (chain_ctrl[CELLS].valid) begin
               found_in      = hit_any;
               found_code_in = hit_code;
               if (chain_ctrl[CELLS].last) begin
                  if (hit_any) begin
                     phrase_in = hit_code;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in = ST_MISS;
                  end
               end
            end
         end
         ST_MISS: begin
            push      = 1'b1;
            push_code = phrase_ff;
            if (!(&free_ff)) begin
               free_in = free_ff + CODE_BITS'(1);
            end
            phrase_in = CODE_BITS'(byte_ff);
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (eos_ff) begin
               push      = 1'b1;
               push_code = phrase_ff;
               push_last = 1'b1;
               open_in   = 1'b0;
               phrase_in = '0;
               free_in   = CODE_BITS'(FIRST_FREE);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      count_in = count_ff + (Q_BITS+1)'(push) - (Q_BITS+1)'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phrase_ff <= '0;
         open_ff   <= 1'b0;
         free_ff   <= CODE_BITS'(FIRST_FREE);
         issue_ff  <= 1'b0;
         found_ff  <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         phrase_ff <= phrase_in;
         open_ff   <= open_in;
         free_ff   <= free_in;
         issue_ff  <= issue_in;
         found_ff  <= found_in;
         count_ff  <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_BITS'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + Q_BITS'(1);
         end
      end
      byte_ff       <= byte_in;
      eos_ff        <= eos_in;
      row_ff        <= row_in;
      found_code_ff <= found_code_in;
      if (push) begin
         q_code_ff[wr_ptr_ff] <= push_code;
         q_last_ff[wr_ptr_ff] <= push_last;
      end
   end

   // code buffer never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_BITS+1)'(Q_DEPTH))
      else $error("code buffer overflow");

   // search beats leave the cell row only while a search runs
   a_beat_in_search: assert property (@(posedge clock) disable iff (reset)
      chain_ctrl[CELLS].valid |-> state_ff == ST_SEARCH)
      else $error("stray search beat at end of cell row");

   // next free code never falls below the first free code
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff >= CODE_BITS'(FIRST_FREE))
      else $error("free code below first free code");

   // a final byte closes the stream and empties the dictionary
   a_stream_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && eos_ff) |=>
         (!open_ff && free_ff == CODE_BITS'(FIRST_FREE)))
      else $error("stream not closed after final byte");

   // a search is only started on an open phrase
   a_search_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_SEARCH) |-> open_ff)
      else $error("search without an open phrase");

endmodule

/* sim/lzw_compressor_12bit_unit_tb.sv */
`timescale 1ns / 1ps

module lzw_compressor_12bit_unit_tb
   import lzwc_pkg::*;
();

   localparam int CODE_BITS  = 12;
   localparam int CODE_SPACE = 1 << CODE_BITS;
   localparam int TDATA_W    = ((CODE_BITS + 7) / 8) * 8;
   localparam int STALL_MAX  = 5000;
   localparam int TAIL_WAIT  = 300;
   localparam int RANDOM_BEATS = 1250;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 last;
   } code_beat_type;

   class code_scoreboard;
      logic [CODE_BITS-1:0] open_code;
      bit                   phrase_live;
      int unsigned          next_code;
      logic [CODE_BITS-1:0] learnt[bit [CODE_BITS+BYTE_BITS-1:0]];
      code_beat_type        pending[$];
      int                   errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         open_code   = '0;
         phrase_live = 1'b0;
         next_code   = FIRST_FREE;
         learnt.delete();
      endfunction

      function void expect_code(logic [CODE_BITS-1:0] code, logic last);
         code_beat_type beat;
         beat.code = code;
         beat.last = last;
         pending.push_back(beat);
      endfunction

      // one accepted input beat: work out the codes it gives
      function void note_byte(logic [7:0] data, logic eos);
         bit [CODE_BITS+BYTE_BITS-1:0] key;
         key = {open_code, data};
         if (!phrase_live) begin
            open_code   = CODE_BITS'(data);
            phrase_live = 1'b1;
         end else if (learnt.exists(key)) begin
            open_code = learnt[key];
         end else begin
            expect_code(open_code, 1'b0);
            // top code is never handed out
            if (next_code + 1 < CODE_SPACE) begin
               learnt[key] = next_code[CODE_BITS-1:0];
               next_code++;
            end
            open_code = CODE_BITS'(data);
         end
         if (eos) begin
            expect_code(open_code, 1'b1);
            restart();
         end
      endfunction

      function void check_code(logic [TDATA_W-1:0] tdata, logic last);
         code_beat_type          beat;
         logic [TDATA_W-1:0]     want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected code beat, expected none actual %h last %b",
                     $time, tdata, last);
            errors++;
            return;
         end
         beat = pending.pop_front();
         want = {{(TDATA_W-CODE_BITS){1'b0}}, beat.code};
         if (tdata !== want) begin
            $display("%0t: code mismatch, expected %h actual %h", $time, want, tdata);
            errors++;
         end
         if (last !== beat.last) begin
            $display("%0t: last flag mismatch, expected %b actual %b",
                     $time, beat.last, last);
            errors++;
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;  // data_byte
   logic               req_tlast  = 1'b0; // end_of_stream
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;        // code
   logic               rsp_tlast;        // last_code

   code_scoreboard sb;
   int calm_req = 0;
   int calm_rsp = 0;
   int beats_sent = 0;
   int stall_count = 0;

   // {eos, byte}: single bytes at both extremes, runs of one byte, alternating
   // extremes, a miss on the final byte
   logic [8:0] directed_beats[$] = '{
      9'h100, 9'h1ff,
      9'h041, 9'h041, 9'h041, 9'h141,
      9'h000, 9'h0ff, 9'h000, 9'h0ff, 9'h000, 9'h0ff, 9'h100,
      9'h012, 9'h134,
      9'h0a5, 9'h05a, 9'h0a5, 9'h05a, 9'h0a5, 9'h15a
   };

   lzw_compressor_12bit_unit #(
      .CODE_BITS(CODE_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // gap before a beat: random, with runs of back-to-back beats now and then
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic eos);
      int gap;
      gap = draw_gap(calm_req);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // flavour 0: any byte, 1: narrow alphabet, 2: repeating motif
   task automatic send_stream(input int len, input int flavour);
      logic [7:0] base;
      logic [7:0] motif[8];
      logic [7:0] data;
      int span;
      int period;
      int i;
      base   = 8'($urandom_range(0, 255));
      span   = $urandom_range(1, 4);
      period = $urandom_range(1, 8);
      for (i = 0; i < 8; i++) motif[i] = 8'($urandom_range(0, 255));
      for (i = 0; i < len; i++) begin
         case (flavour)
            0: data = 8'($urandom_range(0, 255));
            1: data = base + 8'($urandom_range(0, span));
            default: data = motif[i % period];
         endcase
         send_byte(data, i == len - 1);
      end
   endtask

   initial begin
      int len;
      sb = new();
      wait (!reset);
      @(posedge clock);
      foreach (directed_beats[k]) send_byte(directed_beats[k][7:0], directed_beats[k][8]);
      while (beats_sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = $urandom_range(40, 150);
            default: len = $urandom_range(2, 40);
         endcase
         send_stream(len, $urandom_range(0, 2));
      end
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap(calm_rsp);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_code(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_count <= 0;
         end else begin
            stall_count <= stall_count + 1;
         end
         if (stall_count >= STALL_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule
